>>> rtl/core/potential_field_grid_engine_top_macros.svh
`ifndef POTENTIAL_FIELD_GRID_ENGINE_TOP_MACROS_SVH
`define POTENTIAL_FIELD_GRID_ENGINE_TOP_MACROS_SVH

// Assertion helpers for the potential field grid engine.
// Both forms sample on the rising clock edge and are switched off while reset is active.

// The consequent must hold in the same cycle as the antecedent.
`define PFGE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFGE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/pfge_pkg.sv
// -----------------------------------------------------------------------------
// pfge_pkg
// Types, codes and constant tables shared by the potential field grid engine.
// -----------------------------------------------------------------------------
package pfge_pkg;

	// Fixed field widths of the request, result and register interface.
	localparam int CELL_W      = 9;
	localparam int GRID_DIM_W  = 10;
	localparam int RADIUS_W    = 4;
	localparam int SCALE_W     = 10;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 10;

	// Signed coordinate width: centre plus or minus fifteen, with margin.
	localparam int COORD_W  = 12;
	// Signed scan offset width: -15 to +15.
	localparam int OFFSET_W = 5;
	// 3^15 needs 24 bits; scale times that power needs 34.
	localparam int POW3_W = 24;
	localparam int PROD_W = SCALE_W + POW3_W;

	// Action codes.
	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_FIND   = 2'd2;

	// Register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_RADIUS = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WALL_SCALE    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_POINT_SCALE   = 3'd4;

	typedef struct packed {
		logic [1:0]        action;
		logic [CELL_W-1:0] cell_x;
		logic [CELL_W-1:0] cell_y;
		logic              kernel_select;
	} pfge_req_t;

	typedef struct packed {
		logic [CELL_W-1:0] best_x;
		logic [CELL_W-1:0] best_y;
		logic              moved;
	} pfge_rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CENTER,
		ST_CHECK,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} pfge_state_t;

	// Powers of three for the pyramid rings.
	function automatic logic [POW3_W-1:0] pow3(input logic [RADIUS_W-1:0] n);
		logic [POW3_W-1:0] r;
		case (n)
			4'd0:    r = 24'd1;
			4'd1:    r = 24'd3;
			4'd2:    r = 24'd9;
			4'd3:    r = 24'd27;
			4'd4:    r = 24'd81;
			4'd5:    r = 24'd243;
			4'd6:    r = 24'd729;
			4'd7:    r = 24'd2187;
			4'd8:    r = 24'd6561;
			4'd9:    r = 24'd19683;
			4'd10:   r = 24'd59049;
			4'd11:   r = 24'd177147;
			4'd12:   r = 24'd531441;
			4'd13:   r = 24'd1594323;
			4'd14:   r = 24'd4782969;
			4'd15:   r = 24'd14348907;
			default: r = 24'd1;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/pfge_ram.sv
// -----------------------------------------------------------------------------
// pfge_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// -----------------------------------------------------------------------------
module pfge_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/potential_field_grid_engine_top.sv
// -----------------------------------------------------------------------------
// potential_field_grid_engine_top
// Grid of signed potentials with pyramid kernel stamping and window minimum search.
// -----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low, and
// every request gives exactly one result, shown on rsp for a single cycle with
// done high. The receiver cannot hold a result off, so it must take rsp in the
// cycle that done marks. The block works on one request at a time. The grid sits
// in a single memory with one read and one write port, and the scan of a request
// touches one grid cell of that memory per cycle. An add or remove request scans
// every cell of the selected kernel's square, whose side is the kernel size, and
// then drains its last write-back before it gives its result. Cells clipped at
// the edges of the area in use are still stepped through by the scan. A find-min
// request first reads the centre; the search ends there when the centre holds
// zero, and else it scans the window of side 2*search_radius + 1. It goes straight
// to its result when the centre lies outside the area in use, as does an unused
// action code. After reset the block clears the grid one cell per cycle, all
// 2^(2*ceil(log2(GRID_SIDE))) cells (262144 at the default). Busy stays high
// during that pass. Configuration writes are taken at any time, but they must
// only be made while the block is idle.
module potential_field_grid_engine_top
	import pfge_pkg::*;
#(
	parameter int GRID_SIDE         = 512,
	parameter int WALL_KERNEL_SIZE  = 15,
	parameter int POINT_KERNEL_SIZE = 15,
	parameter int VALUE_WIDTH       = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  pfge_req_t              req,
	output logic                   done,
	output pfge_rsp_t              rsp,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// Grid cells are addressed as {x, y}, each coordinate using the bits that the
	// grid side needs.
	localparam int XW    = $clog2(GRID_SIDE);
	localparam int AW    = 2 * XW;
	localparam int DEPTH = 1 << AW;
	localparam logic [RADIUS_W-1:0] WALL_HALF  = RADIUS_W'((WALL_KERNEL_SIZE - 1) / 2);
	localparam logic [RADIUS_W-1:0] POINT_HALF = RADIUS_W'((POINT_KERNEL_SIZE - 1) / 2);

	// Configuration registers.
	logic [GRID_DIM_W-1:0] grid_width_q, grid_height_q;
	logic [RADIUS_W-1:0]   search_radius_q;
	logic [SCALE_W-1:0]    wall_scale_q, point_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q    <= 10'd512;
			grid_height_q   <= 10'd512;
			search_radius_q <= 4'd3;
			wall_scale_q    <= 10'd100;
			point_scale_q   <= 10'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_WIDTH:    grid_width_q    <= cfg_data;
				REG_GRID_HEIGHT:   grid_height_q   <= cfg_data;
				REG_SEARCH_RADIUS: search_radius_q <= cfg_data[RADIUS_W-1:0];
				REG_WALL_SCALE:    wall_scale_q    <= cfg_data;
				REG_POINT_SCALE:   point_scale_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// The area in use is the register setting clipped to the physical grid.
	logic [GRID_DIM_W-1:0] used_w, used_h;
	assign used_w = (32'(grid_width_q) < GRID_SIDE) ? grid_width_q : GRID_DIM_W'(GRID_SIDE);
	assign used_h = (32'(grid_height_q) < GRID_SIDE) ? grid_height_q : GRID_DIM_W'(GRID_SIDE);

	pfge_state_t state_q, state_d;

	// Request registers.
	logic [1:0]                 op_q;
	logic [CELL_W-1:0]          cx_q, cy_q;
	logic                       kern_q;
	logic [RADIUS_W-1:0]        lim_q;
	logic signed [OFFSET_W-1:0] ox_q, oy_q;

	// Clearing pass address.
	logic [AW-1:0] clr_addr_q;

	// Sequencer controls.
	logic load_req, scan_init, scan_step;

	// Memory interface.
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr, ram_raddr;
	logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

	// Read pipeline stage: the cell whose read is in flight.
	logic                      vld_s1;
	logic [AW-1:0]             addr_s1;
	logic signed [COORD_W-1:0] x_s1, y_s1;
	logic [VALUE_WIDTH-1:0]    v_s1;

	// Running minimum of a window search.
	logic                      found_q;
	logic [VALUE_WIDTH-1:0]    best_v_q;
	logic signed [COORD_W-1:0] best_x_q, best_y_q;

	// Cell under the scan: centre plus the current offset.
	logic signed [COORD_W-1:0] scan_x, scan_y;
	logic [COORD_W-2:0]        used_w_ext, used_h_ext;
	logic                      in_area;

	assign scan_x = $signed({{(COORD_W-CELL_W){1'b0}}, cx_q}) +
		{{(COORD_W-OFFSET_W){ox_q[OFFSET_W-1]}}, ox_q};
	assign scan_y = $signed({{(COORD_W-CELL_W){1'b0}}, cy_q}) +
		{{(COORD_W-OFFSET_W){oy_q[OFFSET_W-1]}}, oy_q};
	assign used_w_ext = {{(COORD_W-1-GRID_DIM_W){1'b0}}, used_w};
	assign used_h_ext = {{(COORD_W-1-GRID_DIM_W){1'b0}}, used_h};
	assign in_area = !scan_x[COORD_W-1] && (scan_x[COORD_W-2:0] < used_w_ext) &&
		!scan_y[COORD_W-1] && (scan_y[COORD_W-2:0] < used_h_ext);
	assign ram_raddr = {scan_x[XW-1:0], scan_y[XW-1:0]};

	// The kernel entry depends on the ring: the larger of the two offset magnitudes.
	logic [RADIUS_W-1:0] abs_x, abs_y, ring, pow_idx;
	logic [SCALE_W-1:0]  scale_sel;
	logic [PROD_W-1:0]   kern_prod;

	assign abs_x = ox_q[OFFSET_W-1] ? RADIUS_W'(-ox_q) : ox_q[RADIUS_W-1:0];
	assign abs_y = oy_q[OFFSET_W-1] ? RADIUS_W'(-oy_q) : oy_q[RADIUS_W-1:0];
	assign ring = (abs_x > abs_y) ? abs_x : abs_y;
	assign pow_idx = lim_q - ring;
	assign scale_sel = kern_q ? wall_scale_q : point_scale_q;
	assign kern_prod = PROD_W'(scale_sel) * PROD_W'(pow3(pow_idx));

	// Scan limit for a new request and the wrap test of the offset counters.
	logic [RADIUS_W-1:0]        lim_sel;
	logic signed [OFFSET_W-1:0] neg_lim_sel, neg_lim_q, pos_lim_q;
	logic                       scan_last;
	logic                       centre_out;

	always_comb begin
		if (req.action == ACT_FIND) begin
			lim_sel = search_radius_q;
		end else if (req.kernel_select) begin
			lim_sel = WALL_HALF;
		end else begin
			lim_sel = POINT_HALF;
		end
	end

	assign neg_lim_sel = -$signed({1'b0, lim_sel});
	assign pos_lim_q   = $signed({1'b0, lim_q});
	assign neg_lim_q   = -pos_lim_q;
	assign scan_last   = (ox_q == pos_lim_q) && (oy_q == pos_lim_q);
	assign centre_out  = ({1'b0, req.cell_x} >= used_w) || ({1'b0, req.cell_y} >= used_h);

	// Sequencer: next state and per-state controls.
	always_comb begin
		state_d   = state_q;
		load_req  = 1'b0;
		scan_init = 1'b0;
		scan_step = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == {AW{1'b1}}) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					load_req = 1'b1;
					case (req.action)
						ACT_ADD, ACT_REMOVE: state_d = ST_SCAN;
						ACT_FIND:            state_d = centre_out ? ST_DONE : ST_CENTER;
						default:             state_d = ST_DONE;
					endcase
				end
			end
			ST_CENTER: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				// A centre holding zero ends the search on the spot.
				if (ram_rdata == '0) begin
					state_d = ST_DONE;
				end else begin
					scan_init = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				scan_step = 1'b1;
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Request capture and offset counters. A find starts at offset zero to read the
	// centre first; a stamp starts straight at the corner of its kernel.
	always_ff @(posedge clk) begin
		if (load_req) begin
			op_q   <= req.action;
			cx_q   <= req.cell_x;
			cy_q   <= req.cell_y;
			kern_q <= req.kernel_select;
			lim_q  <= lim_sel;
			if (req.action == ACT_FIND) begin
				ox_q <= '0;
				oy_q <= '0;
			end else begin
				ox_q <= neg_lim_sel;
				oy_q <= neg_lim_sel;
			end
		end else if (scan_init) begin
			ox_q <= neg_lim_q;
			oy_q <= neg_lim_q;
		end else if (scan_step) begin
			if (oy_q == pos_lim_q) begin
				oy_q <= neg_lim_q;
				ox_q <= ox_q + 1'b1;
			end else begin
				oy_q <= oy_q + 1'b1;
			end
		end
	end

	// Read stage: cells outside the area in use are skipped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= scan_step && in_area;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ram_raddr;
		x_s1    <= scan_x;
		y_s1    <= scan_y;
		v_s1    <= VALUE_WIDTH'(kern_prod);
	end

	// Modify and write back. The cells of one stamp are all distinct, and a new
	// request only starts after the last write-back, so a read never meets a
	// pending write to the same cell.
	logic is_stamp;
	logic clearing;

	assign is_stamp  = (op_q == ACT_ADD) || (op_q == ACT_REMOVE);
	assign clearing  = (state_q == ST_CLEAR);
	assign ram_we    = clearing || (vld_s1 && is_stamp);
	assign ram_waddr = clearing ? clr_addr_q : addr_s1;

	always_comb begin
		if (clearing) begin
			ram_wdata = '0;
		end else if (op_q == ACT_REMOVE) begin
			ram_wdata = ram_rdata - v_s1;
		end else begin
			ram_wdata = ram_rdata + v_s1;
		end
	end

	pfge_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(DEPTH)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Window minimum: the first strictly smaller signed value wins, so ties keep
	// the cell met earliest in the scan.
	logic upd_min;

	assign upd_min = vld_s1 && (op_q == ACT_FIND) &&
		(!found_q || ($signed(ram_rdata) < $signed(best_v_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (load_req) begin
			found_q <= 1'b0;
		end else if (upd_min) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_req) begin
			best_x_q <= $signed({{(COORD_W-CELL_W){1'b0}}, req.cell_x});
			best_y_q <= $signed({{(COORD_W-CELL_W){1'b0}}, req.cell_y});
		end else if (upd_min) begin
			best_v_q <= ram_rdata;
			best_x_q <= x_s1;
			best_y_q <= y_s1;
		end
	end

	// Result port.
	assign busy       = (state_q != ST_IDLE);
	assign done       = (state_q == ST_DONE);
	assign rsp.best_x = best_x_q[CELL_W-1:0];
	assign rsp.best_y = best_y_q[CELL_W-1:0];
	assign rsp.moved  = (best_x_q != $signed({{(COORD_W-CELL_W){1'b0}}, cx_q})) ||
		(best_y_q != $signed({{(COORD_W-CELL_W){1'b0}}, cy_q}));

endmodule

>>> rtl/core/pfge_checker.sv
// -----------------------------------------------------------------------------
// pfge_checker
// Port-level checks on the request and result sequencing of the grid engine.
// -----------------------------------------------------------------------------
`include "potential_field_grid_engine_top_macros.svh"

module pfge_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// A result only comes out of a request that is still being served.
	`PFGE_ASSERT_SAME(a_done_while_busy, clk, arst_n, done, busy, "result strobe while idle")
	// An accepted request keeps the block busy in the next cycle.
	`PFGE_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted request not held")
	// One request gives one result: the strobe lasts a single cycle.
	`PFGE_ASSERT_NEXT(a_single_strobe, clk, arst_n, done, !done, "result strobe repeated")
	// After its result the block is free for the next request.
	`PFGE_ASSERT_NEXT(a_free_after_done, clk, arst_n, done, !busy, "busy after result")

endmodule

bind potential_field_grid_engine_top pfge_checker u_pfge_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done)
);
